// File: hw/rtl/radio_channel_plan_fsm_assert.svh
// Assertion macros for the radio channel plan block.
// Used by the top level only; compiled away when SYNTHESIS is defined.
`ifndef RADIO_CHANNEL_PLAN_FSM_ASSERT_SVH
`define RADIO_CHANNEL_PLAN_FSM_ASSERT_SVH
`ifndef SYNTHESIS
`define RCP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("rcp assertion failed");
`define RCP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("rcp assertion failed");
`else
`define RCP_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define RCP_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: hw/rtl/rcp_pkg.sv
// Shared types and constants of the radio channel plan block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package rcp_pkg;

  localparam int MAX_CARDS = 4;
  localparam int TIME_BITS = 32;
  localparam int CARDS_W   = 4;   // holds 0..MAX_CARDS
  localparam int BEACON_W  = 4;
  localparam int DIV_CNT_W = $clog2(TIME_BITS);
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ACK      = 3'd1,
    OP_HOP      = 3'd2,
    OP_CONFIRM  = 3'd3,
    OP_WITHDRAW = 3'd4,
    OP_QUERY    = 3'd5
  } op_t;

  localparam logic [2:0] RSN_COMMIT   = 3'd0;
  localparam logic [2:0] RSN_OVERRIDE = 3'd1;
  localparam logic [2:0] RSN_SPLIT    = 3'd2;
  localparam logic [2:0] RSN_REUNITE  = 3'd3;
  localparam logic [2:0] RSN_HOP_LEAD = 3'd4;
  localparam logic [2:0] RSN_FOLLOW   = 3'd5;
  localparam logic [2:0] RSN_WITHDRAW = 3'd6;
  localparam logic [2:0] RSN_ONE_CARD = 3'd7;

  localparam logic [2:0] REG_HOME         = 3'd0;
  localparam logic [2:0] REG_SPLIT_DELAY  = 3'd1;
  localparam logic [2:0] REG_WINDOW       = 3'd2;
  localparam logic [2:0] REG_BEACON       = 3'd3;
  localparam logic [2:0] REG_CARD_COUNT   = 3'd4;

  localparam logic [2:0] CARD_ALL  = 3'b111;  // -1: all cards or none
  localparam logic [2:0] CARD_ZERO = 3'd0;

  typedef struct packed {
    logic                kind;
    logic [31:0]         move_time;
    logic [2:0]          move_card;
    logic [7:0]          from_channel;
    logic [7:0]          to_channel;
    logic [2:0]          reason;
    logic [7:0]          desired_channel;
    logic                beacon_active;
    logic [BEACON_W-1:0] beacon_mask;
  } rec_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic answer;
    logic out_sel;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       op_valid;
    logic       op_query;
    logic [1:0] rec_cnt_nxt;
    logic [1:0] rec_cnt;
    logic       div_last;
  } sts_t;

  function automatic rec_t mk_move(logic [TIME_BITS-1:0] t, logic [2:0] card,
                                   logic [7:0] from, logic [7:0] to,
                                   logic [2:0] reason);
    rec_t r;
    r                 = '0;
    r.move_time       = 32'(t);
    r.move_card       = card;
    r.from_channel    = from;
    r.to_channel      = to;
    r.reason          = reason;
    return r;
  endfunction

endpackage

// File: hw/rtl/rcp_datapath.sv
// Datapath of the radio channel plan: configuration, link state, move records
// and a one-bit-per-cycle remainder unit. Depends on rcp_pkg.
`timescale 1ns / 1ps
module rcp_datapath import rcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [23:0]           cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [2:0]            in_op,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output rec_t                  rec,
  output logic                  rec_last
);

  // Configuration.
  logic [7:0]  home_r;
  logic [23:0] split_delay_r;
  logic [15:0] window_r;
  logic [15:0] beacon_r;
  logic [2:0]  card_count_r;

  // Captured request.
  logic [2:0]           op_r;
  logic [TIME_BITS-1:0] t_r;
  logic                 sess_r;
  logic [7:0]           agreed_r, proposed_r, target_r;
  logic [2:0]           lead_r;
  logic [1:0]           qcard_r;

  // Link state.
  logic [7:0]           cur_r, cur_nxt;
  logic                 locked_r, locked_nxt;
  logic                 split_r, split_nxt;
  logic                 hop_r, hop_nxt;
  logic                 loss_run_r, loss_run_nxt;
  logic [TIME_BITS-1:0] loss_start_r, loss_start_nxt;
  logic [TIME_BITS-1:0] split_start_r, split_start_nxt;
  logic [TIME_BITS-1:0] hop_start_r, hop_start_nxt;
  logic [7:0]           hop_ch_r, hop_ch_nxt;
  logic [2:0]           hop_card_r, hop_card_nxt;
  logic [7:0]           hop_origin_r, hop_origin_nxt;
  logic [TIME_BITS-1:0] last_time_r, last_time_nxt;

  // Records.
  rec_t       rec0_r, rec0_nxt, rec1_r, rec1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Remainder unit.
  logic [TIME_BITS-1:0] dvd_r;
  logic [15:0]          rem_r, rem_nxt;
  logic                 qbit_r, qbit_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [16:0]          rem_sh;

  logic [15:0]          win_len;
  logic [CARDS_W-1:0]   ncards;
  logic [TIME_BITS-1:0] since;
  rec_t                 ans;

  assign win_len = (window_r == 16'd0) ? 16'd1 : window_r;
  assign since   = last_time_r - split_start_r;

  always_comb begin
    if (card_count_r == 3'd0) begin
      ncards = CARDS_W'(1);
    end else if (CARDS_W'(card_count_r) > CARDS_W'(MAX_CARDS)) begin
      ncards = CARDS_W'(MAX_CARDS);
    end else begin
      ncards = CARDS_W'(card_count_r);
    end
  end

  // Event execution.
  always_comb begin
    logic [TIME_BITS-1:0] ls;
    logic [TIME_BITS-1:0] shifted;
    cur_nxt         = cur_r;
    locked_nxt      = locked_r;
    split_nxt       = split_r;
    hop_nxt         = hop_r;
    loss_run_nxt    = loss_run_r;
    loss_start_nxt  = loss_start_r;
    split_start_nxt = split_start_r;
    hop_start_nxt   = hop_start_r;
    hop_ch_nxt      = hop_ch_r;
    hop_card_nxt    = hop_card_r;
    hop_origin_nxt  = hop_origin_r;
    last_time_nxt   = last_time_r;
    rec0_nxt        = '0;
    rec1_nxt        = '0;
    cnt_nxt         = 2'd0;
    ls              = loss_run_r ? loss_start_r : t_r;
    shifted         = loss_run_r ? (loss_start_r + (t_r - hop_start_r)) : loss_start_r;

    if (op_r <= OP_WITHDRAW) begin
      last_time_nxt = t_r;
    end
    case (op_r)
      OP_TICK: begin
        if (!hop_r) begin
          if (sess_r) begin
            loss_run_nxt = 1'b0;
            if (split_r) begin
              split_nxt = 1'b0;
              rec0_nxt  = mk_move(t_r, CARD_ZERO, home_r, cur_r, RSN_REUNITE);
              cnt_nxt   = 2'd1;
            end
          end else if (locked_r) begin
            loss_run_nxt   = 1'b1;
            loss_start_nxt = ls;
            if (cur_r != home_r && !split_r &&
                (t_r - ls) >= TIME_BITS'(split_delay_r)) begin
              split_nxt       = 1'b1;
              split_start_nxt = t_r;
              rec0_nxt        = mk_move(t_r, CARD_ZERO, cur_r, home_r, RSN_SPLIT);
              cnt_nxt         = 2'd1;
            end
          end
        end
      end
      OP_ACK: begin
        loss_run_nxt = 1'b0;
        if (locked_r && agreed_r == cur_r) begin
          if (split_r) begin
            split_nxt = 1'b0;
            rec0_nxt  = mk_move(t_r, CARD_ZERO, home_r, cur_r, RSN_REUNITE);
            cnt_nxt   = 2'd1;
          end
        end else begin
          cur_nxt    = agreed_r;
          locked_nxt = 1'b1;
          split_nxt  = 1'b0;
          rec0_nxt   = mk_move(t_r, CARD_ALL, cur_r, agreed_r,
                               (agreed_r == proposed_r) ? RSN_COMMIT : RSN_OVERRIDE);
          cnt_nxt    = 2'd1;
        end
      end
      OP_HOP: begin
        hop_nxt        = 1'b1;
        hop_ch_nxt     = target_r;
        hop_card_nxt   = lead_r;
        hop_origin_nxt = cur_r;
        split_nxt      = 1'b0;
        if (hop_r) begin
          // The hop in flight is withdrawn before the new one is led.
          rec0_nxt = mk_move(t_r, hop_card_r, hop_ch_r, cur_r, RSN_WITHDRAW);
          rec1_nxt = mk_move(t_r, lead_r, cur_r, target_r,
                             lead_r[2] ? RSN_ONE_CARD : RSN_HOP_LEAD);
          cnt_nxt  = 2'd2;
        end else begin
          hop_start_nxt = t_r;
          rec0_nxt = mk_move(t_r, lead_r, cur_r, target_r,
                             lead_r[2] ? RSN_ONE_CARD : RSN_HOP_LEAD);
          cnt_nxt  = 2'd1;
        end
      end
      OP_CONFIRM: begin
        if (hop_r) begin
          cur_nxt        = hop_ch_r;
          locked_nxt     = 1'b1;
          hop_nxt        = 1'b0;
          loss_start_nxt = shifted;
          rec0_nxt       = mk_move(t_r, CARD_ALL, hop_origin_r, hop_ch_r, RSN_FOLLOW);
          cnt_nxt        = 2'd1;
        end
      end
      OP_WITHDRAW: begin
        if (hop_r) begin
          hop_nxt        = 1'b0;
          loss_start_nxt = shifted;
          rec0_nxt       = mk_move(t_r, hop_card_r, hop_ch_r, cur_r, RSN_WITHDRAW);
          cnt_nxt        = 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Query answer, built once the remainder unit has finished.
  always_comb begin
    logic                quiet;
    logic [BEACON_W-1:0] mask;
    ans       = '0;
    ans.kind  = 1'b1;
    quiet     = (beacon_r >= win_len) || (rem_r >= (win_len - beacon_r));
    mask      = '0;
    if (hop_r) begin
      ans.desired_channel = (hop_card_r[2] || ({1'b0, qcard_r} == hop_card_r))
                            ? hop_ch_r : cur_r;
    end else if (!split_r) begin
      ans.desired_channel = cur_r;
    end else if (ncards >= CARDS_W'(2)) begin
      ans.desired_channel = (qcard_r == 2'd0) ? home_r : cur_r;
    end else begin
      ans.desired_channel = !qbit_r ? home_r : cur_r;
    end
    if (split_r) begin
      if (ncards >= CARDS_W'(2)) begin
        for (int i = 0; i < BEACON_W; i++) begin
          mask[i] = CARDS_W'(i) < ncards;
        end
      end else begin
        mask[0] = !quiet;
      end
    end
    ans.beacon_active = split_r;
    ans.beacon_mask   = mask;
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem_r, dvd_r[TIME_BITS-1]};
  always_comb begin
    if (rem_sh >= {1'b0, win_len}) begin
      rem_nxt  = 16'(rem_sh - {1'b0, win_len});
      qbit_nxt = 1'b1;
    end else begin
      rem_nxt  = rem_sh[15:0];
      qbit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r        <= 8'd0;
      split_delay_r <= 24'd10000;
      window_r      <= 16'd1000;
      beacon_r      <= 16'd100;
      card_count_r  <= 3'd2;
      cur_r         <= 8'd0;
      locked_r      <= 1'b0;
      split_r       <= 1'b0;
      hop_r         <= 1'b0;
      loss_run_r    <= 1'b0;
      loss_start_r  <= '0;
      split_start_r <= '0;
      hop_start_r   <= '0;
      hop_ch_r      <= 8'd0;
      hop_card_r    <= 3'd0;
      hop_origin_r  <= 8'd0;
      last_time_r   <= '0;
      cnt_r         <= 2'd0;
      div_cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOME: begin
            home_r <= cfg_wdata[7:0];
            if (!locked_r && !hop_r) begin
              cur_r <= cfg_wdata[7:0];
            end
          end
          REG_SPLIT_DELAY: split_delay_r <= cfg_wdata;
          REG_WINDOW:      window_r      <= cfg_wdata[15:0];
          REG_BEACON:      beacon_r      <= cfg_wdata[15:0];
          REG_CARD_COUNT:  card_count_r  <= cfg_wdata[2:0];
          default: begin
          end
        endcase
      end
      if (cmd.exec) begin
        cur_r         <= cur_nxt;
        locked_r      <= locked_nxt;
        split_r       <= split_nxt;
        hop_r         <= hop_nxt;
        loss_run_r    <= loss_run_nxt;
        loss_start_r  <= loss_start_nxt;
        split_start_r <= split_start_nxt;
        hop_start_r   <= hop_start_nxt;
        hop_ch_r      <= hop_ch_nxt;
        hop_card_r    <= hop_card_nxt;
        hop_origin_r  <= hop_origin_nxt;
        last_time_r   <= last_time_nxt;
        cnt_r         <= cnt_nxt;
        div_cnt_r     <= DIV_CNT_W'(TIME_BITS - 1);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
      if (cmd.answer) begin
        cnt_r <= 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_op;
      t_r        <= TIME_BITS'(in_data[31:0]);
      sess_r     <= in_data[32];
      agreed_r   <= in_data[40:33];
      proposed_r <= in_data[48:41];
      target_r   <= in_data[56:49];
      lead_r     <= in_data[59:57];
      qcard_r    <= in_data[61:60];
    end
    if (cmd.exec) begin
      rec0_r <= rec0_nxt;
      rec1_r <= rec1_nxt;
      dvd_r  <= since;
      rem_r  <= 16'd0;
      qbit_r <= 1'b0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[TIME_BITS-2:0], 1'b0};
      rem_r  <= rem_nxt;
      qbit_r <= qbit_nxt;
    end
    if (cmd.answer) begin
      rec0_r <= ans;
    end
  end

  assign sts.op_valid    = (op_r <= OP_QUERY);
  assign sts.op_query    = (op_r == OP_QUERY);
  assign sts.rec_cnt_nxt = cnt_nxt;
  assign sts.rec_cnt     = cnt_r;
  assign sts.div_last    = (div_cnt_r == '0);

  assign rec      = cmd.out_sel ? rec1_r : rec0_r;
  assign rec_last = cmd.out_sel || (cnt_r == 2'd1);

endmodule

// File: hw/rtl/rcp_ctrl.sv
// Controller of the radio channel plan: sequences capture, execution,
// the remainder iterations and result delivery. Depends on rcp_pkg.
`timescale 1ns / 1ps
module rcp_ctrl import rcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DIV  = 6'b000100,
    S_ANS  = 6'b001000,
    S_OUT0 = 6'b010000,
    S_OUT1 = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.op_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.op_query) begin
          state_nxt = S_DIV;
        end else if (sts.rec_cnt_nxt == 2'd0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_OUT0;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ANS;
        end
      end
      S_ANS: begin
        cmd.answer = 1'b1;
        state_nxt  = S_OUT0;
      end
      S_OUT0: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = (sts.rec_cnt == 2'd2) ? S_OUT1 : S_IDLE;
        end
      end
      S_OUT1: begin
        out_tvalid  = 1'b1;
        cmd.out_sel = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/radio_channel_plan_fsm.sv
// Top level of the radio channel plan block: stream ports, controller and
// datapath. Depends on rcp_pkg, rcp_ctrl, rcp_datapath and the assertion header.
`timescale 1ns / 1ps
`include "radio_channel_plan_fsm_assert.svh"
// This block follows which radio channel a link operates on. Each request on
// the input stream is one timed event chosen by the opcode in in_tuser: a
// tick with the session status, a peer ack, a hop order, a hop confirm, a hop
// withdraw or a query; opcodes 6 and 7 are dropped without a result. Events
// produce zero, one or two move records (only a hop order that replaces a hop
// in flight produces two), and a query produces exactly one answer with the
// desired channel of the asked card and the beacon mask; out_tlast marks the
// final result of each request. The block works on one request at a time.
// An event is first accepted, then the link state is updated, then each
// result is offered until the sink takes it. A query's split-window parity
// and quiet gap come from the remainder of the elapsed time over the window
// length, which a restoring divider resolves one bit per cycle over all 32
// time bits. Configuration writes are to be made only while the block is
// idle; the block itself does not enforce it. Writing the home channel also
// moves the current channel when the link is neither locked nor hopping.
// There is no clearing pass after reset.
module radio_channel_plan_fsm import rcp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [23:0]            cfg_wdata,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata from bit 0: time_ms[31:0], session flag[32], agreed_channel[40:33],
  // proposed_channel[48:41], target_channel[56:49], leading card[59:57],
  // query_card[61:60], zero fill[63:62].
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // in_tuser: opcode[2:0].
  input  logic [2:0]             in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata from bit 0: move_time[31:0], move_card[34:32],
  // from_channel[42:35], to_channel[50:43], reason[53:51],
  // desired_channel[61:54], beacon_active[62], beacon_mask[66:63],
  // zero fill[71:67].
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: kind (0 move record, 1 query answer).
  output logic                   out_tuser,
  output logic                   out_tlast
);

  cmd_t cmd;
  sts_t sts;
  rec_t rec;
  logic rec_last;

  rcp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rcp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .in_op     (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .rec       (rec),
    .rec_last  (rec_last)
  );

  // The records are held in the datapath until taken, so the payload is
  // stable for as long as out_tvalid waits on out_tready.
  assign out_tdata = {5'd0, rec.beacon_mask, rec.beacon_active, rec.desired_channel,
                      rec.reason, rec.to_channel, rec.from_channel, rec.move_card,
                      rec.move_time};
  assign out_tuser = rec.kind;
  assign out_tlast = rec_last;

  // A request is never taken while a result is still on offer.
  `RCP_ASSERT_IMP(a_no_overlap, clk, rst_n, in_tready, !out_tvalid)
  // A first record that is not last is followed directly by the second one.
  `RCP_ASSERT_NXT(a_second_follows, clk, rst_n,
                  out_tvalid && out_tready && !out_tlast, out_tvalid)
  // A query answer is always the only result of its request.
  `RCP_ASSERT_IMP(a_answer_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  // Without an active split no card is asked to beacon.
  `RCP_ASSERT_IMP(a_mask_split, clk, rst_n,
                  out_tvalid && out_tuser && !out_tdata[62], out_tdata[66:63] == 4'd0)

endmodule
